// File: design/assert_macros.svh
// Assertion macros used by the mutex unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIMU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIMU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/pimu_pkg.sv
package pimu_pkg;

	localparam int NUM_TASKS   = 16;
	localparam int NUM_MUTEXES = 8;
	localparam int PRIO_BITS   = 8;

	localparam int OP_W    = 2;
	localparam int TASK_W  = 4;
	localparam int MTX_W   = 3;
	localparam int PRIO_W  = 8;
	localparam int STAT_W  = 3;
	localparam int DEPTH_W = 16;
	localparam int CNT_W   = $clog2(NUM_TASKS + 1);
	localparam int Q_DEPTH = NUM_MUTEXES * NUM_TASKS;
	localparam int QADDR_W = MTX_W + TASK_W;

	localparam logic [OP_W-1:0] OP_LOCK   = 2'd0;
	localparam logic [OP_W-1:0] OP_UNLOCK = 2'd1;
	localparam logic [OP_W-1:0] OP_SETPRI = 2'd2;

	localparam logic [STAT_W-1:0] ST_ACQUIRED = 3'd0;
	localparam logic [STAT_W-1:0] ST_NESTED   = 3'd1;
	localparam logic [STAT_W-1:0] ST_BLOCKED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_NEST_REL = 3'd3;
	localparam logic [STAT_W-1:0] ST_FREED    = 3'd4;
	localparam logic [STAT_W-1:0] ST_HANDED   = 3'd5;
	localparam logic [STAT_W-1:0] ST_NOT_OWN  = 3'd6;
	localparam logic [STAT_W-1:0] ST_PRI_SET  = 3'd7;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	typedef logic [TASK_W-1:0] task_t;
	typedef logic [PRIO_W-1:0] prio_t;

endpackage

// File: design/pimu_req_if.sv
interface pimu_req_if;
	import pimu_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       op;
	logic [TASK_W-1:0]     task_id;
	logic [MTX_W-1:0]      mutex_id;
	logic [PRIO_W-1:0]     new_priority;

	modport source (output valid, op, task_id, mutex_id, new_priority, input ready);
	modport sink (input valid, op, task_id, mutex_id, new_priority, output ready);

endinterface

// File: design/pimu_rsp_if.sv
interface pimu_rsp_if;
	import pimu_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STAT_W-1:0]     status;
	logic                  woken_valid;
	logic [TASK_W-1:0]     woken_task;
	logic [PRIO_W-1:0]     caller_priority;
	logic [PRIO_W-1:0]     owner_priority;

	modport source (output valid, status, woken_valid, woken_task, caller_priority,
		owner_priority, input ready);
	modport sink (input valid, status, woken_valid, woken_task, caller_priority,
		owner_priority, output ready);

endinterface

// File: design/pimu_ram.sv
module pimu_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/priority_inheritance_mutex_unit.sv
// Priority-inheritance mutex table for eight recursive mutexes and sixteen tasks.
// Requests arrive on the req channel (lock, unlock or set base priority) and each
// request produces exactly one word on the rsp channel, in request order.
// The unit handles one request at a time: req.ready is high only while idle.
// The sequencer sets the path: an uncontended or nested lock and a nested unlock
// update the table directly; a blocking lock scans the waiter queue and shifts
// entries to insert the caller by priority; set priority and a final unlock run a
// recalculation scan over the mutexes, and a hand-over then moves the waiter
// queue held in a RAM with one read port and one write port.
// The response is held in an output register, so a new request is taken while
// a finished word waits; a stalled receiver holds that word, and the unit then
// waits in its last state until the register is free.
// Reset clears the ownership table, nesting depths, queue counts and all
// priorities; the waiter RAM needs no clearing, as only counted entries are read.
`include "assert_macros.svh"

module priority_inheritance_mutex_unit import pimu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pimu_req_if.sink    req,
	pimu_rsp_if.source  rsp
);

	localparam int SW = 5;
	localparam logic [SW-1:0] S_IDLE    = 5'd0;
	localparam logic [SW-1:0] S_DISP    = 5'd1;
	localparam logic [SW-1:0] S_LK_P    = 5'd2;
	localparam logic [SW-1:0] S_SC_RD   = 5'd3;
	localparam logic [SW-1:0] S_SC_CK   = 5'd4;
	localparam logic [SW-1:0] S_SH_INIT = 5'd5;
	localparam logic [SW-1:0] S_SH_RD   = 5'd6;
	localparam logic [SW-1:0] S_SH_WR   = 5'd7;
	localparam logic [SW-1:0] S_PROP    = 5'd8;
	localparam logic [SW-1:0] S_RC_RD   = 5'd9;
	localparam logic [SW-1:0] S_RC_CK   = 5'd10;
	localparam logic [SW-1:0] S_RC_WR   = 5'd11;
	localparam logic [SW-1:0] S_DQ_RD   = 5'd12;
	localparam logic [SW-1:0] S_DQ_HD   = 5'd13;
	localparam logic [SW-1:0] S_DQ_MV   = 5'd14;
	localparam logic [SW-1:0] S_DQ_WR   = 5'd15;
	localparam logic [SW-1:0] S_OUT1    = 5'd16;
	localparam logic [SW-1:0] S_OUT2    = 5'd17;
	localparam logic [SW-1:0] S_OUT3    = 5'd18;
	localparam logic [SW-1:0] S_FIN     = 5'd19;

	localparam logic [MTX_W-1:0] MTX_LAST = MTX_W'(NUM_MUTEXES - 1);

	logic [SW-1:0]       state_q;
	logic [OP_W-1:0]     op_q;
	task_t               t_q;
	logic [MTX_W-1:0]    m_q;
	logic [MTX_W-1:0]    mx_q;
	task_t               ex_q;
	logic [CNT_W-1:0]    i_q;
	logic [CNT_W-1:0]    pos_q;
	logic                pf_q;
	logic                dup_q;
	prio_t               p_q;
	prio_t               best_q;
	task_t               head_q;
	logic [STAT_W-1:0]   st_q;
	logic                wv_q;
	task_t               wt_q;
	prio_t               cp_q;
	prio_t               opr_q;

	logic                own_v_q [NUM_MUTEXES];
	task_t               own_t_q [NUM_MUTEXES];
	logic [DEPTH_W-1:0]  depth_q [NUM_MUTEXES];
	logic [CNT_W-1:0]    cnt_q   [NUM_MUTEXES];
	prio_t               base_q  [NUM_TASKS];
	prio_t               eff_q   [NUM_TASKS];

	logic                out_v_q;
	logic [STAT_W-1:0]   out_st_q;
	logic                out_wv_q;
	task_t               out_wt_q;
	prio_t               out_cp_q;
	prio_t               out_op_q;

	logic                ram_we;
	logic [QADDR_W-1:0]  ram_waddr;
	task_t               ram_wdata;
	logic [QADDR_W-1:0]  ram_raddr;
	task_t               ram_rdata;
	logic [CNT_W-1:0]    ra_idx;
	task_t               eff_ri;
	prio_t               eff_rd;
	logic                out_free;
	logic                own_hit;

	pimu_ram #(.WIDTH(TASK_W), .DEPTH(Q_DEPTH)) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		eff_ri = (state_q == S_SC_CK || state_q == S_RC_CK) ? ram_rdata : ex_q;
		eff_rd = eff_q[eff_ri];
		own_hit = own_v_q[mx_q] && (own_t_q[mx_q] == t_q);
		case (state_q)
			S_SH_RD: ra_idx = i_q - CNT_W'(1);
			S_RC_RD: ra_idx = '0;
			S_DQ_RD: ra_idx = '0;
			default: ra_idx = i_q;
		endcase
		ram_raddr = {mx_q, ra_idx[TASK_W-1:0]};
		ram_we    = 1'b0;
		ram_waddr = {mx_q, i_q[TASK_W-1:0]};
		ram_wdata = ram_rdata;
		case (state_q)
			S_SH_RD: begin
				if (i_q == pos_q) begin
					ram_we    = 1'b1;
					ram_waddr = {mx_q, pos_q[TASK_W-1:0]};
					ram_wdata = t_q;
				end
			end
			S_SH_WR: begin
				ram_we = 1'b1;
			end
			S_DQ_WR: begin
				ram_we    = 1'b1;
				ram_waddr = {mx_q, ra_idx[TASK_W-1:0] - TASK_W'(1)};
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign out_free  = !out_v_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			mx_q    <= '0;
			for (int k = 0; k < NUM_MUTEXES; k++) begin
				own_v_q[k] <= 1'b0;
				depth_q[k] <= '0;
				cnt_q[k]   <= '0;
			end
			for (int k = 0; k < NUM_TASKS; k++) begin
				base_q[k] <= '0;
				eff_q[k]  <= '0;
			end
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_v_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.op;
						t_q     <= req.task_id;
						m_q     <= req.mutex_id;
						mx_q    <= req.mutex_id;
						ex_q    <= req.task_id;
						best_q  <= req.new_priority;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					wv_q  <= 1'b0;
					wt_q  <= '0;
					i_q   <= '0;
					pf_q  <= 1'b0;
					dup_q <= 1'b0;
					case (op_q)
						OP_LOCK: begin
							if (!own_v_q[mx_q]) begin
								own_v_q[mx_q] <= 1'b1;
								own_t_q[mx_q] <= t_q;
								depth_q[mx_q] <= DEPTH_W'(1);
								st_q          <= ST_ACQUIRED;
								state_q       <= S_OUT1;
							end else if (own_hit) begin
								if (depth_q[mx_q] != DEPTH_MAX) begin
									depth_q[mx_q] <= depth_q[mx_q] + DEPTH_W'(1);
								end
								st_q    <= ST_NESTED;
								state_q <= S_OUT1;
							end else begin
								state_q <= S_LK_P;
							end
						end
						OP_UNLOCK: begin
							if (own_hit) begin
								if (depth_q[mx_q] > DEPTH_W'(1)) begin
									depth_q[mx_q] <= depth_q[mx_q] - DEPTH_W'(1);
									st_q          <= ST_NEST_REL;
									state_q       <= S_OUT1;
								end else begin
									depth_q[mx_q] <= '0;
									own_v_q[mx_q] <= 1'b0;
									best_q        <= base_q[t_q];
									mx_q          <= '0;
									state_q       <= S_RC_RD;
								end
							end else begin
								st_q    <= ST_NOT_OWN;
								state_q <= S_OUT1;
							end
						end
						OP_SETPRI: begin
							base_q[t_q] <= best_q;
							mx_q        <= '0;
							state_q     <= S_RC_RD;
						end
						default: begin
							st_q    <= ST_NOT_OWN;
							state_q <= S_OUT1;
						end
					endcase
				end
				S_LK_P: begin
					p_q     <= eff_rd;
					pos_q   <= cnt_q[mx_q];
					state_q <= S_SC_RD;
				end
				S_SC_RD: begin
					state_q <= (i_q == cnt_q[mx_q]) ? S_SH_INIT : S_SC_CK;
				end
				S_SC_CK: begin
					if (ram_rdata == t_q) begin
						dup_q <= 1'b1;
					end
					if (!pf_q && (eff_rd < p_q)) begin
						pos_q <= i_q;
						pf_q  <= 1'b1;
					end
					i_q     <= i_q + CNT_W'(1);
					state_q <= S_SC_RD;
				end
				S_SH_INIT: begin
					ex_q <= own_t_q[mx_q];
					i_q  <= cnt_q[mx_q];
					if (dup_q || (cnt_q[mx_q] >= CNT_W'(NUM_TASKS))) begin
						state_q <= S_PROP;
					end else begin
						state_q <= S_SH_RD;
					end
				end
				S_SH_RD: begin
					if (i_q == pos_q) begin
						cnt_q[mx_q] <= cnt_q[mx_q] + CNT_W'(1);
						state_q     <= S_PROP;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					i_q     <= i_q - CNT_W'(1);
					state_q <= S_SH_RD;
				end
				S_PROP: begin
					if (p_q > eff_rd) begin
						eff_q[ex_q] <= p_q;
					end
					st_q    <= ST_BLOCKED;
					state_q <= S_OUT1;
				end
				S_RC_RD: begin
					if (own_hit && (cnt_q[mx_q] != '0)) begin
						state_q <= S_RC_CK;
					end else if (mx_q == MTX_LAST) begin
						state_q <= S_RC_WR;
					end else begin
						mx_q <= mx_q + MTX_W'(1);
					end
				end
				S_RC_CK: begin
					if (eff_rd > best_q) begin
						best_q <= eff_rd;
					end
					if (mx_q == MTX_LAST) begin
						state_q <= S_RC_WR;
					end else begin
						mx_q    <= mx_q + MTX_W'(1);
						state_q <= S_RC_RD;
					end
				end
				S_RC_WR: begin
					eff_q[t_q] <= best_q;
					mx_q       <= m_q;
					if (op_q == OP_UNLOCK) begin
						if (cnt_q[m_q] != '0) begin
							state_q <= S_DQ_RD;
						end else begin
							st_q    <= ST_FREED;
							state_q <= S_OUT1;
						end
					end else begin
						st_q    <= ST_PRI_SET;
						state_q <= S_OUT1;
					end
				end
				S_DQ_RD: begin
					i_q     <= CNT_W'(1);
					state_q <= S_DQ_HD;
				end
				S_DQ_HD: begin
					head_q  <= ram_rdata;
					state_q <= S_DQ_MV;
				end
				S_DQ_MV: begin
					if (i_q == cnt_q[mx_q]) begin
						cnt_q[mx_q]   <= cnt_q[mx_q] - CNT_W'(1);
						own_v_q[mx_q] <= 1'b1;
						own_t_q[mx_q] <= head_q;
						depth_q[mx_q] <= DEPTH_W'(1);
						wv_q          <= 1'b1;
						wt_q          <= head_q;
						st_q          <= ST_HANDED;
						state_q       <= S_OUT1;
					end else begin
						state_q <= S_DQ_WR;
					end
				end
				S_DQ_WR: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= S_DQ_MV;
				end
				S_OUT1: begin
					ex_q    <= t_q;
					state_q <= S_OUT2;
				end
				S_OUT2: begin
					cp_q    <= eff_rd;
					ex_q    <= own_t_q[mx_q];
					state_q <= S_OUT3;
				end
				S_OUT3: begin
					opr_q   <= own_v_q[mx_q] ? eff_rd : '0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_st_q <= st_q;
						out_wv_q <= wv_q;
						out_wt_q <= wt_q;
						out_cp_q <= cp_q;
						out_op_q <= opr_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid           = out_v_q;
	assign rsp.status          = out_st_q;
	assign rsp.woken_valid     = out_wv_q;
	assign rsp.woken_task      = out_wt_q;
	assign rsp.caller_priority = out_cp_q;
	assign rsp.owner_priority  = out_op_q;

	`PIMU_ASSERT_NOW(a_owner_depth, 1'b1, own_v_q[mx_q] == (depth_q[mx_q] != '0), "owner and depth disagree")
	`PIMU_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q[mx_q] <= CNT_W'(NUM_TASKS), "waiter count overflow")
	`PIMU_ASSERT_NOW(a_handover, out_v_q && (out_st_q == ST_HANDED), out_wv_q, "hand-over without woken task")
	`PIMU_ASSERT_NEXT(a_busy, req.valid && req.ready, !req.ready, "request taken while busy")

endmodule
